// ===== sv/tsv_pkg.sv =====
// ---------------------------------------------------------------------------
// tsv_pkg: shared types and constants
// Request and status codes, header offsets and the item/result structs.
// ---------------------------------------------------------------------------
package tsv_pkg;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// register indexes (byte address = 4 * index)
	localparam logic REG_MAX_NAME_LEN = 1'b0;
	localparam logic [15:0] MAX_NAME_LEN_RST = 16'd255;

	// request codes
	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_ABSENT = 2'd1;
	localparam logic [1:0] REQ_EMPTY  = 2'd2;

	// status codes
	localparam logic [1:0] ST_VALID     = 2'd0;
	localparam logic [1:0] ST_ABSENT    = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
	localparam logic [16:0] NAME_OFFSET = 17'd5;
	localparam logic [7:0]  HOST_NAME_TYPE = 8'd0;
	localparam logic [17:0] LIST_HDR_LEN = 18'd2;   // bytes of the list length field
	localparam logic [16:0] NAME_HDR_LEN = 17'd3;   // name type + name length

	// header byte positions
	localparam logic [16:0] POS_LIST_HI = 17'd0;
	localparam logic [16:0] POS_LIST_LO = 17'd1;
	localparam logic [16:0] POS_TYPE    = 17'd2;
	localparam logic [16:0] POS_NAME_HI = 17'd3;
	localparam logic [16:0] POS_NAME_LO = 17'd4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic        emit;
		logic [1:0]  status;
		logic [15:0] name_length;
	} result_t;

endpackage

// ===== sv/tsv_regs.sv =====
// ---------------------------------------------------------------------------
// tsv_regs: configuration register file
// APB-style slave holding max_name_len; pready tied high.
// ---------------------------------------------------------------------------
module tsv_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsv_pkg::ADDR_W-1:0]  paddr,
	input  logic [tsv_pkg::DATA_W-1:0]  pwdata,
	output logic [tsv_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output logic [15:0]                 max_name_len
);
	import tsv_pkg::*;

	logic [15:0] max_name_len_q;
	logic        reg_hit;

	// word index lives at paddr[2]; low bits are byte offset
	assign reg_hit = (paddr[2] == REG_MAX_NAME_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q <= MAX_NAME_LEN_RST;
		end else if (psel && penable && pwrite && reg_hit) begin
			max_name_len_q <= pwdata[15:0];
		end
	end

	assign pready       = 1'b1;
	assign prdata       = reg_hit ? {{(DATA_W-16){1'b0}}, max_name_len_q} : '0;
	assign max_name_len = max_name_len_q;

endmodule

// ===== sv/tsv_parse.sv =====
// ---------------------------------------------------------------------------
// tsv_parse: extension byte parser
// Holds per-extension state and forms the verdict for the current byte.
// ---------------------------------------------------------------------------
module tsv_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  tsv_pkg::item_t   item,
	input  logic [15:0]      max_name_len,
	output tsv_pkg::result_t res
);
	import tsv_pkg::*;

	logic [16:0] byte_count_q;
	logic [15:0] list_length_q;
	logic [15:0] host_length_q;
	logic        bad_seen_q;

	logic [15:0] list_n;
	logic [15:0] host_n;
	logic        bad_n;
	logic [16:0] count_n;
	logic [16:0] name_end;
	logic [17:0] total;
	logic        ok;

	assign name_end = {1'b0, host_length_q} + NAME_OFFSET;

	always_comb begin
		list_n = list_length_q;
		host_n = host_length_q;
		bad_n  = bad_seen_q;
		priority if (byte_count_q == POS_LIST_HI) begin
			list_n = {item.data_byte, 8'h00};
		end else if (byte_count_q == POS_LIST_LO) begin
			list_n = {list_length_q[15:8], item.data_byte};
		end else if (byte_count_q == POS_TYPE) begin
			if (item.data_byte != HOST_NAME_TYPE) bad_n = 1'b1;
		end else if (byte_count_q == POS_NAME_HI) begin
			host_n = {item.data_byte, 8'h00};
		end else if (byte_count_q == POS_NAME_LO) begin
			host_n = {host_length_q[15:8], item.data_byte};
		end else if (byte_count_q < name_end) begin
			if (item.data_byte == 8'h00) bad_n = 1'b1;
		end else begin
			// trailing bytes past the name are ignored
		end
	end

	assign count_n = (byte_count_q != COUNT_MAX) ? byte_count_q + 17'd1 : byte_count_q;
	assign total   = {1'b0, byte_count_q} + 18'd1;

	assign ok = (total >= LIST_HDR_LEN)
		&& (total >= LIST_HDR_LEN + {2'b00, list_n})
		&& ({1'b0, list_n} >= NAME_HDR_LEN)
		&& !bad_n
		&& ({1'b0, host_n} + NAME_HDR_LEN == {1'b0, list_n})
		&& (host_n != 16'd0)
		&& (host_n <= max_name_len);

	always_comb begin
		res = '0;
		unique case (item.req_type)
			REQ_ABSENT: begin
				res.emit   = 1'b1;
				res.status = ST_ABSENT;
			end
			REQ_EMPTY: begin
				res.emit   = 1'b1;
				res.status = ST_MALFORMED;
			end
			REQ_BYTE: begin
				res.emit        = item.last_byte;
				res.status      = ok ? ST_VALID : ST_MALFORMED;
				res.name_length = ok ? host_n : 16'd0;
			end
			default: begin
				// unused code: no result
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			list_length_q <= '0;
			host_length_q <= '0;
			bad_seen_q    <= 1'b0;
		end else if (fire) begin
			if (item.req_type == REQ_ABSENT || item.req_type == REQ_EMPTY ||
			    (item.req_type == REQ_BYTE && item.last_byte)) begin
				byte_count_q  <= '0;
				list_length_q <= '0;
				host_length_q <= '0;
				bad_seen_q    <= 1'b0;
			end else if (item.req_type == REQ_BYTE) begin
				byte_count_q  <= count_n;
				list_length_q <= list_n;
				host_length_q <= host_n;
				bad_seen_q    <= bad_n;
			end
		end
	end

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.emit |=> byte_count_q == 17'd0 && !bad_seen_q)
		else $error("parser state not cleared after result");

	a_valid_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit && res.status == ST_VALID |->
			res.name_length != 16'd0 && res.name_length <= max_name_len)
		else $error("valid verdict with out-of-range length");

endmodule

// ===== sv/tls_sni_extension_validator.sv =====
// Path: an accepted transfer goes through one input register, then the parse logic into
//   the result register, which drives out_valid.
// Throughput: one item per cycle; an item with a result waits in the input register
//   only while out_valid is high and out_ready is low.
// Reset (arst_n low, asynchronous): pipeline and result emptied, parser state cleared,
//   max_name_len back to 255.
// ---------------------------------------------------------------------------
// tls_sni_extension_validator: TLS server_name extension checker
// Streams extension bytes and reports one verdict per extension.
// ---------------------------------------------------------------------------
module tls_sni_extension_validator (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsv_pkg::ADDR_W-1:0]  paddr,
	input  logic [tsv_pkg::DATA_W-1:0]  pwdata,
	output logic [tsv_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [15:0]                 name_length
);
	import tsv_pkg::*;

	logic [15:0] max_name_len;

	// input register
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;      // stage-1 item moves through the parser this cycle
	result_t res;

	// result register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] name_length_q;
	logic        out_load;

	tsv_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.max_name_len (max_name_len)
	);

	tsv_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.item         (item_s1),
		.max_name_len (max_name_len),
		.res          (res)
	);

	// An item that yields no result never waits; one that does waits only
	// while the result register holds an untaken transfer.
	assign advance  = valid_s1 && (!res.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_load = advance && res.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type  <= req_type;
			item_s1.data_byte <= data_byte;
			item_s1.last_byte <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q      <= res.status;
			name_length_q <= res.name_length;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign name_length = name_length_q;

	// a stalled stage-1 item must not be dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stage-1 item lost while stalled");

	// result register never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || out_ready)
		else $error("result overwritten before transfer");

	a_len_zero_unless_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_VALID |-> name_length_q == 16'd0)
		else $error("nonzero name_length on non-valid status");

endmodule
